// ===== sv/lmm_pkg.sv =====
// ----------------------------------------------------------------------------
// lmm_pkg
// Shared constants, codes, types and helpers of the landmark map merge table.
// ----------------------------------------------------------------------------
package lmm_pkg;

   localparam int MAX_ENTRIES_DEF = 32;
   localparam int RADIUS_RESET    = 100;

   // item kinds
   localparam logic [2:0] KIND_POSE     = 3'd0;
   localparam logic [2:0] KIND_OBSERVE  = 3'd1;
   localparam logic [2:0] KIND_LOAD     = 3'd2;
   localparam logic [2:0] KIND_LIST_W   = 3'd3;
   localparam logic [2:0] KIND_LIST_REL = 3'd4;

   // result status codes
   localparam logic [2:0] ST_LISTED   = 3'd0;
   localparam logic [2:0] ST_MERGED   = 3'd1;
   localparam logic [2:0] ST_APPENDED = 3'd2;
   localparam logic [2:0] ST_DROPPED  = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   // rotator
   localparam int          CORDIC_STAGES = 16;
   localparam logic [16:0] CORDIC_K      = 17'd39797;
   localparam int          ROT_W         = 28;   // working width of x and y
   localparam int          ANG_W         = 26;   // angle in 2^-24 turn
   localparam int          RES_W         = 20;   // rotated result width

   typedef struct packed {
      logic                    done;
      logic signed [RES_W-1:0] x;
      logic signed [RES_W-1:0] y;
   } rot_res_type;

   function automatic logic signed [ANG_W-1:0] atan_lut(input logic [3:0] idx);
      logic signed [ANG_W-1:0] v;
      case (idx)
         4'd0:    v = 26'sd2097152;
         4'd1:    v = 26'sd1238021;
         4'd2:    v = 26'sd654136;
         4'd3:    v = 26'sd332050;
         4'd4:    v = 26'sd166669;
         4'd5:    v = 26'sd83416;
         4'd6:    v = 26'sd41718;
         4'd7:    v = 26'sd20860;
         4'd8:    v = 26'sd10430;
         4'd9:    v = 26'sd5215;
         4'd10:   v = 26'sd2608;
         4'd11:   v = 26'sd1304;
         4'd12:   v = 26'sd652;
         4'd13:   v = 26'sd326;
         4'd14:   v = 26'sd163;
         default: v = 26'sd81;
      endcase
      return v;
   endfunction

   // clamp a 21-bit signed value into 16 bits
   function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
      logic signed [15:0] r;
      if (v > 21'sd32767)       r = 16'sh7FFF;
      else if (v < -21'sd32768) r = 16'sh8000;
      else                      r = v[15:0];
      return r;
   endfunction

endpackage

// ===== sv/lmm_if.sv =====
// ----------------------------------------------------------------------------
// lmm_if
// Request and response channels of the landmark map merge table.
// ----------------------------------------------------------------------------
interface lmm_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         kind;
   logic signed [15:0] pos_x;
   logic signed [15:0] pos_y;
   logic [15:0]        heading;
   logic [11:0]        range_mm;
   logic [15:0]        bearing;
   logic               first_entry;

   modport source (output valid, kind, pos_x, pos_y, heading, range_mm, bearing,
                   first_entry, input ready);
   modport sink   (input valid, kind, pos_x, pos_y, heading, range_mm, bearing,
                   first_entry, output ready);
endinterface

interface lmm_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic [4:0]         entry_index;
   logic [2:0]         status;
   logic               last;

   modport source (output valid, out_x, out_y, entry_index, status, last, input ready);
   modport sink   (input valid, out_x, out_y, entry_index, status, last, output ready);
endinterface

// ===== sv/lmm_ram.sv =====
// ----------------------------------------------------------------------------
// lmm_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== sv/lmm_cordic.sv =====
// ----------------------------------------------------------------------------
// lmm_cordic
// Iterative CORDIC rotator: one micro-rotation per cycle, then gain multiply.
// ----------------------------------------------------------------------------
module lmm_cordic (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [16:0]        vec_x,
   input  logic signed [16:0]        vec_y,
   input  logic [15:0]               angle,
   output lmm_pkg::rot_res_type      res
);

   localparam int ITW = $clog2(lmm_pkg::CORDIC_STAGES);
   localparam int PW  = lmm_pkg::ROT_W + 17;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_ITER = 2'd1;
   localparam logic [1:0] PH_MUL  = 2'd2;
   localparam logic [1:0] PH_OUT  = 2'd3;

   logic [1:0]                          phase_ff, phase_in;
   logic [ITW-1:0]                      it_ff, it_in;
   logic signed [lmm_pkg::ROT_W-1:0]    x_ff, x_in, y_ff, y_in;
   logic signed [lmm_pkg::ANG_W-1:0]    z_ff, z_in;
   logic signed [PW-1:0]                px_ff, px_in, py_ff, py_in;
   logic signed [PW-1:0]                rnd_x, rnd_y;
   logic                                flip;
   logic [15:0]                         ang_r;
   logic signed [16:0]                  sx, sy;

   // half-plane fold, iteration step and gain multiply
   always_comb begin
      phase_in = phase_ff;
      it_in    = it_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      flip     = angle inside {[16'h4000 : 16'hBFFF]};
      ang_r    = flip ? 16'(angle - 16'h8000) : angle;
      sx       = flip ? 17'(-vec_x) : vec_x;
      sy       = flip ? 17'(-vec_y) : vec_y;
      case (phase_ff)
         PH_IDLE: begin
            if (start) begin
               x_in     = {{(lmm_pkg::ROT_W-25){sx[16]}}, sx, 8'd0};
               y_in     = {{(lmm_pkg::ROT_W-25){sy[16]}}, sy, 8'd0};
               z_in     = {{(lmm_pkg::ANG_W-24){ang_r[15]}}, ang_r, 8'd0};
               it_in    = '0;
               phase_in = PH_ITER;
            end
         end
         PH_ITER: begin
            if (!z_ff[lmm_pkg::ANG_W-1]) begin
               x_in = x_ff - (y_ff >>> it_ff);
               y_in = y_ff + (x_ff >>> it_ff);
               z_in = z_ff - lmm_pkg::atan_lut(4'(it_ff));
            end else begin
               x_in = x_ff + (y_ff >>> it_ff);
               y_in = y_ff - (x_ff >>> it_ff);
               z_in = z_ff + lmm_pkg::atan_lut(4'(it_ff));
            end
            it_in = ITW'(it_ff + 1'b1);
            if (it_ff == ITW'(lmm_pkg::CORDIC_STAGES - 1)) begin
               phase_in = PH_MUL;
            end
         end
         PH_MUL: begin
            px_in    = PW'(x_ff) * PW'($signed({1'b0, lmm_pkg::CORDIC_K[15:0]}));
            py_in    = PW'(y_ff) * PW'($signed({1'b0, lmm_pkg::CORDIC_K[15:0]}));
            phase_in = PH_OUT;
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   // round and scale back
   assign rnd_x    = px_ff + (PW'(1) <<< 23);
   assign rnd_y    = py_ff + (PW'(1) <<< 23);
   assign res.done = (phase_ff == PH_OUT);
   assign res.x    = rnd_x[24 +: lmm_pkg::RES_W];
   assign res.y    = rnd_y[24 +: lmm_pkg::RES_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      it_ff <= it_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      z_ff  <= z_in;
      px_ff <= px_in;
      py_ff <= py_in;
   end

endmodule

// ===== sv/landmark_map_merge_table.sv =====
// ----------------------------------------------------------------------------
// landmark_map_merge_table
// Bounded obstacle table with distance-gated merge, rotation via CORDIC.
// ----------------------------------------------------------------------------
// An observation is rotated, then entries are read, squared and compared in
// turn until one merges, else it is appended or dropped. A load writes when
// accepted; a pose update sends no response. A relative list rotates each entry.
// One item is in work at a time; throughput is set by the shared rotator and
// the one-read-per-cycle table RAM.
// Reset clears count and pose, sets merge radius to 100; table RAM is kept.
module landmark_map_merge_table #(
   parameter int MAX_ENTRIES = lmm_pkg::MAX_ENTRIES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_we,
   input  logic [14:0]  csr_wdata,
   lmm_req_if.sink      req_chan,
   lmm_rsp_if.source    rsp_chan
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_ROT  = 3'd1;
   localparam logic [2:0] S_RD   = 3'd2;
   localparam logic [2:0] S_SQ   = 3'd3;
   localparam logic [2:0] S_CMP  = 3'd4;
   localparam logic [2:0] S_END  = 3'd5;
   localparam logic [2:0] S_OUT  = 3'd6;

   logic [2:0]         state_ff, state_in;
   logic [2:0]         kind_ff, kind_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in, scan_ff, scan_in;
   logic signed [15:0] pose_x_ff, pose_x_in, pose_y_ff, pose_y_in;
   logic [15:0]        pose_h_ff, pose_h_in;
   logic [14:0]        radius_ff;
   logic [29:0]        r2_ff;
   logic signed [15:0] px_ff, px_in, gx_ff, gx_in, gy_ff, gy_in;
   logic [33:0]        sqx_ff, sqx_in, sqy_ff, sqy_in;
   // staged result
   logic signed [15:0] st_x_ff, st_x_in, st_y_ff, st_y_in;
   logic [IDX_W-1:0]   st_idx_ff, st_idx_in;
   logic [2:0]         st_status_ff, st_status_in;
   logic               st_last_ff, st_last_in;
   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic [IDX_W-1:0]   rsp_idx_ff;
   logic [2:0]         rsp_status_ff;
   logic               rsp_last_ff;
   logic [IDX_W+4:0]   idx_ext;
   logic               out_free;
   // table RAM
   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [31:0]        ram_wdata, ram_rdata;
   logic signed [15:0] ent_x, ent_y;
   logic signed [16:0] dx, dy;
   logic [16:0]        sum_x, sum_y;
   logic [CNT_W-1:0]   eff_cnt;
   // rotator
   logic               rot_start;
   logic signed [16:0] rot_vx, rot_vy;
   logic [15:0]        rot_ang;
   lmm_pkg::rot_res_type rot_res;
   logic               accept;

   lmm_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (scan_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   lmm_cordic u_rot (
      .clock  (clock),
      .reset  (reset),
      .start  (rot_start),
      .vec_x  (rot_vx),
      .vec_y  (rot_vy),
      .angle  (rot_ang),
      .res    (rot_res)
   );

   assign req_chan.ready = (state_ff == S_IDLE);
   assign accept         = req_chan.valid && req_chan.ready;
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign ent_x          = ram_rdata[31:16];
   assign ent_y          = ram_rdata[15:0];
   assign dx             = 17'(ent_x) - 17'(gx_ff);
   assign dy             = 17'(ent_y) - 17'(gy_ff);
   assign sum_x          = 17'(ent_x) + 17'(gx_ff);
   assign sum_y          = 17'(ent_y) + 17'(gy_ff);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      cnt_in       = cnt_ff;
      scan_in      = scan_ff;
      pose_x_in    = pose_x_ff;
      pose_y_in    = pose_y_ff;
      pose_h_in    = pose_h_ff;
      px_in        = px_ff;
      gx_in        = gx_ff;
      gy_in        = gy_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      st_x_in      = st_x_ff;
      st_y_in      = st_y_ff;
      st_idx_in    = st_idx_ff;
      st_status_in = st_status_ff;
      st_last_in   = st_last_ff;
      ram_we       = 1'b0;
      ram_waddr    = cnt_ff[IDX_W-1:0];
      ram_wdata    = {gx_ff, gy_ff};
      rot_start    = 1'b0;
      rot_vx       = 17'(req_chan.range_mm);
      rot_vy       = '0;
      rot_ang      = 16'(req_chan.heading + req_chan.bearing);
      eff_cnt      = (req_chan.first_entry) ? '0 : cnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               kind_in = req_chan.kind;
               px_in   = req_chan.pos_x;
               gy_in   = req_chan.pos_y;
               case (req_chan.kind)
                  lmm_pkg::KIND_POSE: begin
                     pose_x_in = req_chan.pos_x;
                     pose_y_in = req_chan.pos_y;
                     pose_h_in = req_chan.heading;
                  end
                  lmm_pkg::KIND_OBSERVE: begin
                     rot_start = 1'b1;
                     state_in  = S_ROT;
                  end
                  lmm_pkg::KIND_LOAD: begin
                     st_x_in    = req_chan.pos_x;
                     st_y_in    = req_chan.pos_y;
                     st_last_in = 1'b1;
                     if (eff_cnt < CNT_W'(MAX_ENTRIES)) begin
                        ram_we       = 1'b1;
                        ram_waddr    = eff_cnt[IDX_W-1:0];
                        ram_wdata    = {req_chan.pos_x, req_chan.pos_y};
                        st_idx_in    = eff_cnt[IDX_W-1:0];
                        st_status_in = lmm_pkg::ST_APPENDED;
                        cnt_in       = CNT_W'(eff_cnt + 1'b1);
                     end else begin
                        cnt_in       = eff_cnt;
                        st_idx_in    = '0;
                        st_status_in = lmm_pkg::ST_DROPPED;
                     end
                     state_in = S_OUT;
                  end
                  lmm_pkg::KIND_LIST_W, lmm_pkg::KIND_LIST_REL: begin
                     scan_in = '0;
                     if (cnt_ff == '0) begin
                        st_x_in      = '0;
                        st_y_in      = '0;
                        st_idx_in    = '0;
                        st_status_in = lmm_pkg::ST_EMPTY;
                        st_last_in   = 1'b1;
                        state_in     = S_OUT;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_ROT: begin
            if (rot_res.done) begin
               if (kind_ff == lmm_pkg::KIND_OBSERVE) begin
                  gx_in   = lmm_pkg::sat16(21'(px_ff) + 21'(rot_res.x));
                  gy_in   = lmm_pkg::sat16(21'(gy_ff) + 21'(rot_res.y));
                  scan_in = '0;
                  state_in = (cnt_ff == '0) ? S_END : S_RD;
               end else begin
                  st_x_in      = lmm_pkg::sat16(21'(rot_res.x));
                  st_y_in      = lmm_pkg::sat16(21'(rot_res.y));
                  st_idx_in    = scan_ff[IDX_W-1:0];
                  st_status_in = lmm_pkg::ST_LISTED;
                  st_last_in   = (CNT_W'(scan_ff + 1'b1) == cnt_ff);
                  state_in     = S_OUT;
               end
            end
         end
         S_RD: begin
            state_in = S_SQ;
         end
         S_SQ: begin
            rot_vx  = 17'(ent_x) - 17'(pose_x_ff);
            rot_vy  = 17'(ent_y) - 17'(pose_y_ff);
            rot_ang = 16'(16'd0 - pose_h_ff);
            if (kind_ff == lmm_pkg::KIND_OBSERVE) begin
               sqx_in   = 34'(dx * dx);
               sqy_in   = 34'(dy * dy);
               st_x_in  = 16'(sum_x >> 1) | {sum_x[16], 15'd0};
               st_y_in  = 16'(sum_y >> 1) | {sum_y[16], 15'd0};
               state_in = S_CMP;
            end else if (kind_ff == lmm_pkg::KIND_LIST_REL) begin
               rot_start = 1'b1;
               state_in  = S_ROT;
            end else begin
               st_x_in      = ent_x;
               st_y_in      = ent_y;
               st_idx_in    = scan_ff[IDX_W-1:0];
               st_status_in = lmm_pkg::ST_LISTED;
               st_last_in   = (CNT_W'(scan_ff + 1'b1) == cnt_ff);
               state_in     = S_OUT;
            end
         end
         S_CMP: begin
            if ((35'(sqx_ff) + 35'(sqy_ff)) < 35'(r2_ff)) begin
               ram_we       = 1'b1;
               ram_waddr    = scan_ff[IDX_W-1:0];
               ram_wdata    = {st_x_ff, st_y_ff};
               st_idx_in    = scan_ff[IDX_W-1:0];
               st_status_in = lmm_pkg::ST_MERGED;
               st_last_in   = 1'b1;
               state_in     = S_OUT;
            end else begin
               scan_in  = CNT_W'(scan_ff + 1'b1);
               state_in = (CNT_W'(scan_ff + 1'b1) == cnt_ff) ? S_END : S_RD;
            end
         end
         S_END: begin
            // no match: append or drop
            st_x_in    = gx_ff;
            st_y_in    = gy_ff;
            st_last_in = 1'b1;
            if (cnt_ff < CNT_W'(MAX_ENTRIES)) begin
               ram_we       = 1'b1;
               st_idx_in    = cnt_ff[IDX_W-1:0];
               st_status_in = lmm_pkg::ST_APPENDED;
               cnt_in       = CNT_W'(cnt_ff + 1'b1);
            end else begin
               st_idx_in    = '0;
               st_status_in = lmm_pkg::ST_DROPPED;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               if (st_last_ff) begin
                  state_in = S_IDLE;
               end else begin
                  scan_in  = CNT_W'(scan_ff + 1'b1);
                  state_in = S_RD;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         pose_x_ff    <= '0;
         pose_y_ff    <= '0;
         pose_h_ff    <= '0;
         radius_ff    <= 15'(lmm_pkg::RADIUS_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         pose_x_ff <= pose_x_in;
         pose_y_ff <= pose_y_in;
         pose_h_ff <= pose_h_in;
         if (csr_we) begin
            radius_ff <= csr_wdata;
         end
         if ((state_ff == S_OUT) && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      r2_ff        <= radius_ff * radius_ff;
      kind_ff      <= kind_in;
      scan_ff      <= scan_in;
      px_ff        <= px_in;
      gx_ff        <= gx_in;
      gy_ff        <= gy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      st_x_ff      <= st_x_in;
      st_y_ff      <= st_y_in;
      st_idx_ff    <= st_idx_in;
      st_status_ff <= st_status_in;
      st_last_ff   <= st_last_in;
      if ((state_ff == S_OUT) && out_free) begin
         rsp_x_ff      <= st_x_ff;
         rsp_y_ff      <= st_y_ff;
         rsp_idx_ff    <= st_idx_ff;
         rsp_status_ff <= st_status_ff;
         rsp_last_ff   <= st_last_ff;
      end
   end

   // response beat
   assign idx_ext              = {5'd0, rsp_idx_ff};
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.out_x       = rsp_x_ff;
   assign rsp_chan.out_y       = rsp_y_ff;
   assign rsp_chan.entry_index = idx_ext[4:0];
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.last        = rsp_last_ff;

   // checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ENTRIES))
      else $error("entry count above table size");

   a_rot_done_state: assert property (@(posedge clock) disable iff (reset)
      rot_res.done |-> state_ff == S_ROT)
      else $error("rotator finished outside rotate wait");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RD |-> scan_ff < cnt_ff)
      else $error("scan read beyond filled entries");

endmodule
